// File: rtl/core/chc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chc_pkg
// Shared types and fixed field widths of the canonical Huffman codec.
// ----------------------------------------------------------------------------
package chc_pkg;

  localparam int SYM_W  = 8;
  localparam int LEN_W  = 5;
  localparam int CODE_W = 16;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_BUILD  = 2'd1,
    KIND_ENCODE = 2'd2,
    KIND_DECODE = 2'd3
  } kind_t;

  // One classified command as it travels from the front to the back.
  typedef struct packed {
    kind_t              kind;
    logic [SYM_W-1:0]   sym;
    logic [LEN_W-1:0]   len;
    logic [CODE_W-1:0]  bits;
    logic               sym_ok;   // symbol is inside the alphabet
    logic               len_le;   // length does not exceed the maximum
    logic               len_ok;   // length is nonzero and in range
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/canonical_huffman_codec_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// canonical_huffman_codec_top
// Canonical Huffman code table builder, encoder and decoder for byte symbols.
// ----------------------------------------------------------------------------
// Usage: each input beat carries a command kind in in_tuser (load length,
// build codes, encode symbol, decode code) and its operands in in_tdata.
// Every input beat yields exactly one output beat, in order. Load beats
// produce an all-zero result; build beats produce an all-zero result once
// the code tables are complete. Encode returns the code and length of a
// symbol; decode returns the symbol matching a length and code.
// A decode scans the candidate codes of the given length, and a build
// counts lengths over all symbols, forms per-length offsets, places the
// present symbols and assigns their codes. The rate is set by the
// single back-end sequencer and the one read port of each table memory.
// A two-entry queue decouples input acceptance from the sequencer, so the
// block takes new beats while a result waits in the output register.
// Reset clears all lengths (no symbols present) and the per-length counts.
// When the receiver stalls, the result holds and the back end waits.
// ----------------------------------------------------------------------------
module canonical_huffman_codec_top
  import chc_pkg::*;
#(
  parameter int SYMBOLS = 256,
  parameter int MAX_LEN = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // symbol[7:0], code_length[12:8], code_bits[28:13]
  input  wire logic [1:0]  in_tuser,   // kind[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // out_code[15:0], out_length[20:16], out_symbol[28:21]
  output logic [0:0]       out_tuser   // found[0]
);

  logic              q_valid, q_pop, found;
  cmd_t              q_cmd;
  logic [CODE_W-1:0] o_code;
  logic [LEN_W-1:0]  o_len;
  logic [SYM_W-1:0]  o_sym;

  chc_front #(.SYMBOLS(SYMBOLS), .MAX_LEN(MAX_LEN)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_kind  (kind_t'(in_tuser)),
    .in_sym   (in_tdata[7:0]),
    .in_len   (in_tdata[12:8]),
    .in_bits  (in_tdata[28:13]),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  chc_back #(.SYMBOLS(SYMBOLS), .MAX_LEN(MAX_LEN)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_code  (o_code),
    .out_len   (o_len),
    .out_sym   (o_sym),
    .out_found (found)
  );

  assign out_tdata = {3'b000, o_sym, o_len, o_code};
  assign out_tuser = found;

endmodule
`default_nettype wire

// File: rtl/core/chc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chc_front
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module chc_front
  import chc_pkg::*;
#(
  parameter int SYMBOLS = 256,
  parameter int MAX_LEN = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire kind_t             in_kind,
  input  wire logic [SYM_W-1:0]  in_sym,
  input  wire logic [LEN_W-1:0]  in_len,
  input  wire logic [CODE_W-1:0] in_bits,
  output logic                   q_valid,
  output cmd_t                   q_cmd,
  input  wire logic              q_pop
);

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       cls;
  logic       push;

  always_comb begin
    cls.kind   = in_kind;
    cls.sym    = in_sym;
    cls.len    = in_len;
    cls.bits   = in_bits;
    cls.sym_ok = ({1'b0, in_sym} < 9'(SYMBOLS));
    cls.len_le = ({1'b0, in_len} <= 6'(MAX_LEN));
    cls.len_ok = (in_len != '0) && ({1'b0, in_len} <= 6'(MAX_LEN));
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/chc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chc_back
// Sequencer that owns the tables: loads lengths, builds canonical codes,
// encodes and decodes, and holds one result in an output register.
// ----------------------------------------------------------------------------
module chc_back
  import chc_pkg::*;
#(
  parameter int SYMBOLS = 256,
  parameter int MAX_LEN = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire cmd_t              q_cmd,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CODE_W-1:0]      out_code,
  output logic [LEN_W-1:0]       out_len,
  output logic [SYM_W-1:0]       out_sym,
  output logic                   out_found
);

  localparam int AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int CW = $clog2(SYMBOLS + 1);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int OW = $clog2(MAX_LEN + 2);

  typedef enum logic [3:0] {
    S_IDLE, S_ENC, S_CNT_A, S_CNT_B, S_OFS, S_PLC_A, S_PLC_B,
    S_ASG_A, S_ASG_B, S_ASG_C, S_DEC_A, S_DEC_B, S_DEC_C
  } state_t;

  state_t             st_r;
  cmd_t               cmd_r;
  logic [CW-1:0]      idx_r;
  logic [OW-1:0]      l_r;
  logic [CW-1:0]      cnt_r  [MAX_LEN+1];
  logic [CW-1:0]      ofs_r  [MAX_LEN+2];
  logic [CW-1:0]      npos_r [MAX_LEN+1];
  logic [CODE_W-1:0]  code_r;
  logic [LW-1:0]      prev_r;
  logic [CW-1:0]      dec_idx_r, dec_left_r;

  // Table memories, each with one write and one registered read port.
  logic [LW-1:0]      len_mem  [SYMBOLS];
  logic [CODE_W-1:0]  code_mem [SYMBOLS];
  logic [AW-1:0]      srt_mem  [SYMBOLS];
  logic [SYMBOLS-1:0] len_vld_r;
  logic [LW-1:0]      len_rd_r;
  logic               len_vld_rd_r;
  logic [CODE_W-1:0]  code_rd_r;
  logic [AW-1:0]      srt_rd_r;

  logic [AW-1:0]      len_ra, len_wa, code_ra, code_wa, srt_ra, srt_wa;
  logic               len_we, code_we, srt_we;
  logic [LW-1:0]      len_wd, len_eff, sh_d;
  logic [CODE_W-1:0]  code_wd;
  logic [AW-1:0]      srt_wd;
  logic [CODE_W:0]    c_inc;
  logic [31:0]        c_sh;
  logic [CW-1:0]      total;

  assign len_eff = len_vld_rd_r ? len_rd_r : '0;
  assign total   = ofs_r[MAX_LEN+1];
  assign q_pop   = (st_r == S_IDLE) && q_valid && !out_valid;
  assign c_inc   = {1'b0, code_r} + 1'b1;
  assign sh_d    = (len_eff > prev_r) ? (len_eff - prev_r) : '0;
  assign c_sh    = 32'(c_inc) << sh_d;

  always_comb begin
    len_ra  = idx_r[AW-1:0];
    code_ra = q_cmd.sym[AW-1:0];
    srt_ra  = idx_r[AW-1:0];
    len_we  = 1'b0;
    len_wa  = q_cmd.sym[AW-1:0];
    len_wd  = q_cmd.len_le ? LW'(q_cmd.len) : '0;
    code_we = 1'b0;
    code_wa = srt_rd_r;
    code_wd = (idx_r == '0) ? code_r : c_sh[CODE_W-1:0];
    srt_we  = 1'b0;
    srt_wa  = npos_r[len_eff][AW-1:0];
    srt_wd  = idx_r[AW-1:0];
    case (st_r)
      S_IDLE: begin
        len_ra = q_cmd.sym[AW-1:0];
        len_we = q_pop && (q_cmd.kind == KIND_LOAD) && q_cmd.sym_ok;
      end
      S_PLC_B: srt_we = (len_eff != '0);
      S_ASG_B: len_ra = srt_rd_r;
      S_ASG_C: code_we = 1'b1;
      S_DEC_A, S_DEC_B, S_DEC_C: begin
        srt_ra  = dec_idx_r[AW-1:0];
        code_ra = srt_rd_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_wa] <= len_wd;
    if (code_we) code_mem[code_wa] <= code_wd;
    if (srt_we) srt_mem[srt_wa] <= srt_wd;
    len_rd_r     <= len_mem[len_ra];
    len_vld_rd_r <= len_vld_r[len_ra];
    code_rd_r    <= code_mem[code_ra];
    srt_rd_r     <= srt_mem[srt_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_vld_r <= '0;
    end else if (len_we) begin
      len_vld_r[len_wa] <= 1'b1;
    end
  end

  // Main sequencer with the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i <= MAX_LEN; i++) cnt_r[i] <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_pop) begin
            cmd_r     <= q_cmd;
            out_code  <= '0;
            out_len   <= '0;
            out_sym   <= '0;
            out_found <= 1'b0;
            case (q_cmd.kind)
              KIND_LOAD: out_valid <= 1'b1;
              KIND_BUILD: begin
                for (int i = 0; i <= MAX_LEN; i++) cnt_r[i] <= '0;
                idx_r <= '0;
                st_r  <= S_CNT_A;
              end
              KIND_ENCODE: st_r <= S_ENC;
              KIND_DECODE: begin
                if (q_cmd.len_ok) begin
                  dec_idx_r  <= ofs_r[OW'(q_cmd.len)];
                  dec_left_r <= cnt_r[LW'(q_cmd.len)];
                  st_r       <= S_DEC_A;
                end else begin
                  out_valid <= 1'b1;
                end
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        S_ENC: begin
          if (cmd_r.sym_ok && (len_eff != '0)) begin
            out_code  <= code_rd_r;
            out_len   <= LEN_W'(len_eff);
            out_found <= 1'b1;
          end
          out_valid <= 1'b1;
          st_r      <= S_IDLE;
        end
        S_CNT_A: st_r <= S_CNT_B;
        S_CNT_B: begin
          if (len_eff != '0) cnt_r[len_eff] <= cnt_r[len_eff] + 1'b1;
          if (idx_r == CW'(SYMBOLS - 1)) begin
            ofs_r[0] <= '0;
            l_r      <= '0;
            st_r     <= S_OFS;
          end else begin
            idx_r <= idx_r + 1'b1;
            st_r  <= S_CNT_A;
          end
        end
        S_OFS: begin
          ofs_r[l_r + 1'b1]  <= ofs_r[l_r] + cnt_r[LW'(l_r)];
          npos_r[LW'(l_r)]   <= ofs_r[l_r];
          if (l_r == OW'(MAX_LEN)) begin
            idx_r <= '0;
            st_r  <= S_PLC_A;
          end else begin
            l_r <= l_r + 1'b1;
          end
        end
        S_PLC_A: st_r <= S_PLC_B;
        S_PLC_B: begin
          if (len_eff != '0) npos_r[len_eff] <= npos_r[len_eff] + 1'b1;
          if (idx_r == CW'(SYMBOLS - 1)) begin
            idx_r  <= '0;
            code_r <= '0;
            prev_r <= '0;
            if (total == '0) begin
              out_valid <= 1'b1;
              st_r      <= S_IDLE;
            end else begin
              st_r <= S_ASG_A;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
            st_r  <= S_PLC_A;
          end
        end
        S_ASG_A: st_r <= S_ASG_B;
        S_ASG_B: st_r <= S_ASG_C;
        S_ASG_C: begin
          code_r <= code_wd;
          prev_r <= len_eff;
          if (idx_r + 1'b1 == total) begin
            out_valid <= 1'b1;
            st_r      <= S_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
            st_r  <= S_ASG_A;
          end
        end
        S_DEC_A: begin
          if ((dec_left_r == '0) || ({1'b0, dec_idx_r} >= (CW+1)'(SYMBOLS))) begin
            out_valid <= 1'b1;
            st_r      <= S_IDLE;
          end else begin
            st_r <= S_DEC_B;
          end
        end
        S_DEC_B: st_r <= S_DEC_C;
        S_DEC_C: begin
          if (code_rd_r == cmd_r.bits) begin
            out_sym   <= SYM_W'(srt_rd_r);
            out_found <= 1'b1;
            out_valid <= 1'b1;
            st_r      <= S_IDLE;
          end else begin
            dec_idx_r  <= dec_idx_r + 1'b1;
            dec_left_r <= dec_left_r - 1'b1;
            st_r       <= S_DEC_A;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rise_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(st_r) != S_CNT_A) else $error("result from count sweep");
  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !out_valid) else $error("command taken while result pending");
  a_dec_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DEC_C) |=> (st_r == S_IDLE || st_r == S_DEC_A))
    else $error("decode scan left its loop");
  a_asg_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_ASG_A) |-> (idx_r < total)) else $error("assign index past total");
`endif

endmodule
`default_nettype wire
